// File: src/ple_pkg.sv
`default_nettype none

package ple_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned WIDTH = 32;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned OPW   = 3;
  localparam int unsigned POSW  = 5;
  localparam int unsigned LENW  = 5;
  localparam int unsigned STW   = 2;

  typedef enum logic [OPW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_READ_AT    = 3'd2,
    OP_INSERT_AT  = 3'd3,
    OP_DELETE_AT  = 3'd4,
    OP_CLEAR      = 3'd5
  } ple_op_e;

  typedef enum logic [STW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ple_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPEN,
    S_WRITE,
    S_RD_CAP,
    S_DEL_CAP,
    S_CLOSE,
    S_RESULT
  } ple_state_e;

  typedef struct packed {
    logic [OPW-1:0]   opcode;
    logic [POSW-1:0]  position;
    logic [WIDTH-1:0] value;
  } ple_cmd_t;

  typedef struct packed {
    logic [WIDTH-1:0] read_value;
    logic [STW-1:0]   status;
    logic [LENW-1:0]  length;
  } ple_res_t;

  // request to the shared address stepper
  typedef struct packed {
    logic [AW-1:0] cur;
    logic [AW-1:0] lim;
    logic          up;
  } ple_step_req_t;

  typedef struct packed {
    logic [AW-1:0] nxt;
    logic          hit;
  } ple_step_rsp_t;

  typedef struct packed {
    logic             we;
    logic [AW-1:0]    waddr;
    logic [WIDTH-1:0] wdata;
    logic [AW-1:0]    raddr;
  } ple_mem_req_t;

endpackage

`default_nettype wire

// File: src/ple_step.sv
`default_nettype none

// Shared address stepper: one increment/decrement and one limit compare.
module ple_step (
  input  wire ple_pkg::ple_step_req_t req_i,
  output ple_pkg::ple_step_rsp_t      rsp_o
);

  always_comb begin
    if (req_i.up) begin
      rsp_o.nxt = req_i.cur + ple_pkg::AW'(1);
    end else begin
      rsp_o.nxt = req_i.cur - ple_pkg::AW'(1);
    end
    rsp_o.hit = (req_i.cur == req_i.lim);
  end

endmodule

`default_nettype wire

// File: src/ple_store.sv
`default_nettype none

// Entry storage: one write port, one read port with registered data.
module ple_store (
  input  wire                           clk_i,
  input  wire ple_pkg::ple_mem_req_t    req_i,
  output logic [ple_pkg::WIDTH-1:0]     rdata_o
);

  logic [ple_pkg::WIDTH-1:0] mem_q [ple_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

`default_nettype wire

// File: src/positional_list_engine_core.sv
`default_nettype none

// Positional list engine: a packed ordered list of up to 16 words, front at
// index 0.
//
// Command channel: cmd_i (opcode, position, value) is taken at a rising edge
// with start high and busy low. busy stays high until the result is out.
// Result channel: done_o is high for exactly one cycle with result_o
// (read_value, status, length); the receiver takes it in that cycle and
// cannot hold it off, so the block never stalls on the output side.
//
// States from the accepting edge to the done cycle:
//   clear, unused opcode, any error      : decode, result
//   read, push or insert without a shift : decode, capture or write, result
//   insert or push that moves entries    : decode, an open step per entry moved, write, result
//   delete that moves entries            : decode, capture, a close step per entry moved, result
// The next command is taken only after the return to idle. The entry store
// sets the pace of the sweeps: with one write port and a registered read
// port the sequencer moves one entry per cycle.
//
// Reset clears the length and the sequencer; stored words are not cleared
// and only words below the current length are ever returned or moved.
module positional_list_engine_core (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start,
  output logic                    busy,
  input  wire ple_pkg::ple_cmd_t  cmd_i,
  output logic                    done_o,
  output ple_pkg::ple_res_t       result_o
);

  ple_pkg::ple_state_e  state_q, state_d;
  ple_pkg::ple_cmd_t    cmd_q;
  ple_pkg::ple_status_e st_q, st_d;

  logic [ple_pkg::CW-1:0]    count_q, count_d;
  logic [ple_pkg::AW-1:0]    cur_q, cur_d;    // address being read
  logic [ple_pkg::AW-1:0]    wa_q, wa_d;      // address the read data goes to
  logic [ple_pkg::AW-1:0]    lim_q, lim_d;    // last address of the sweep
  logic [ple_pkg::WIDTH-1:0] rd_q, rd_d;

  ple_pkg::ple_step_req_t    step_req;
  ple_pkg::ple_step_rsp_t    step_rsp;
  ple_pkg::ple_mem_req_t     mem_req;
  logic [ple_pkg::WIDTH-1:0] rdata;

  logic                   accept;
  logic [ple_pkg::CW-1:0] pos_eff;
  logic [ple_pkg::CW-1:0] count_m1;
  logic                   is_put;
  logic                   is_access;
  logic                   put_range;
  logic                   put_full;
  logic                   put_shift;
  logic                   acc_range;

  assign busy   = (state_q != ple_pkg::S_IDLE);
  assign accept = start && !busy;

  // Step down while opening a gap, up while closing one.
  assign step_req.cur = cur_q;
  assign step_req.lim = lim_q;
  assign step_req.up  = (state_q == ple_pkg::S_DEL_CAP) || (state_q == ple_pkg::S_CLOSE);

  ple_step u_step (
    .req_i (step_req),
    .rsp_o (step_rsp)
  );

  ple_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Command decode on the held command.
  always_comb begin
    is_put    = 1'b0;
    is_access = 1'b0;
    pos_eff   = ple_pkg::CW'(cmd_q.position);
    case (ple_pkg::ple_op_e'(cmd_q.opcode))
      ple_pkg::OP_PUSH_FRONT: begin
        is_put  = 1'b1;
        pos_eff = '0;
      end
      ple_pkg::OP_PUSH_BACK: begin
        is_put  = 1'b1;
        pos_eff = count_q;
      end
      ple_pkg::OP_INSERT_AT: begin
        is_put = 1'b1;
      end
      ple_pkg::OP_READ_AT,
      ple_pkg::OP_DELETE_AT: begin
        is_access = 1'b1;
      end
      default: begin
      end
    endcase
    count_m1  = count_q - ple_pkg::CW'(1);
    // range check comes before the full check
    put_range = (pos_eff > count_q);
    put_full  = (count_q >= ple_pkg::CW'(ple_pkg::DEPTH));
    put_shift = (pos_eff != count_q);
    acc_range = (ple_pkg::CW'(cmd_q.position) >= count_q) ||
                (cmd_q.position > ple_pkg::POSW'(ple_pkg::DEPTH));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ple_pkg::S_IDLE: begin
        if (accept) state_d = ple_pkg::S_DECODE;
      end
      ple_pkg::S_DECODE: begin
        if (is_put) begin
          if (put_range || put_full) begin
            state_d = ple_pkg::S_RESULT;
          end else if (put_shift) begin
            state_d = ple_pkg::S_OPEN;
          end else begin
            state_d = ple_pkg::S_WRITE;
          end
        end else if (is_access && !acc_range) begin
          if (ple_pkg::ple_op_e'(cmd_q.opcode) == ple_pkg::OP_READ_AT) begin
            state_d = ple_pkg::S_RD_CAP;
          end else begin
            state_d = ple_pkg::S_DEL_CAP;
          end
        end else begin
          state_d = ple_pkg::S_RESULT;
        end
      end
      ple_pkg::S_OPEN: begin
        if (step_rsp.hit) state_d = ple_pkg::S_WRITE;
      end
      ple_pkg::S_WRITE:  state_d = ple_pkg::S_RESULT;
      ple_pkg::S_RD_CAP: state_d = ple_pkg::S_RESULT;
      ple_pkg::S_DEL_CAP,
      ple_pkg::S_CLOSE: begin
        if (step_rsp.hit) begin
          state_d = ple_pkg::S_RESULT;
        end else begin
          state_d = ple_pkg::S_CLOSE;
        end
      end
      ple_pkg::S_RESULT: state_d = ple_pkg::S_IDLE;
      default:           state_d = ple_pkg::S_IDLE;
    endcase
  end

  // Datapath control: store ports and result registers.
  always_comb begin
    count_d = count_q;
    cur_d   = cur_q;
    wa_d    = wa_q;
    lim_d   = lim_q;
    rd_d    = rd_q;
    st_d    = st_q;

    mem_req.we    = 1'b0;
    mem_req.waddr = wa_q;
    mem_req.wdata = rdata;
    mem_req.raddr = step_rsp.nxt;

    case (state_q)
      ple_pkg::S_DECODE: begin
        rd_d = '0;
        st_d = ple_pkg::ST_OK;
        if (is_put) begin
          if (put_range) begin
            st_d = ple_pkg::ST_RANGE;
          end else if (put_full) begin
            st_d = ple_pkg::ST_FULL;
          end else begin
            // sweep down from the tail, opening a gap at the target
            lim_d         = pos_eff[ple_pkg::AW-1:0];
            cur_d         = count_m1[ple_pkg::AW-1:0];
            wa_d          = count_q[ple_pkg::AW-1:0];
            mem_req.raddr = count_m1[ple_pkg::AW-1:0];
          end
        end else if (is_access) begin
          if (acc_range) begin
            st_d = ple_pkg::ST_RANGE;
          end else begin
            lim_d         = count_m1[ple_pkg::AW-1:0];
            cur_d         = cmd_q.position[ple_pkg::AW-1:0];
            mem_req.raddr = cmd_q.position[ple_pkg::AW-1:0];
          end
        end else if (ple_pkg::ple_op_e'(cmd_q.opcode) == ple_pkg::OP_CLEAR) begin
          count_d = '0;
        end
      end
      ple_pkg::S_OPEN: begin
        mem_req.we = 1'b1;
        if (!step_rsp.hit) begin
          cur_d = step_rsp.nxt;
          wa_d  = cur_q;
        end
      end
      ple_pkg::S_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = lim_q;
        mem_req.wdata = cmd_q.value;
        count_d       = count_q + ple_pkg::CW'(1);
      end
      ple_pkg::S_RD_CAP: begin
        rd_d = rdata;
      end
      ple_pkg::S_DEL_CAP: begin
        rd_d = rdata;
        if (step_rsp.hit) begin
          count_d = count_m1;
        end else begin
          cur_d = step_rsp.nxt;
          wa_d  = cur_q;
        end
      end
      ple_pkg::S_CLOSE: begin
        mem_req.we = 1'b1;
        if (step_rsp.hit) begin
          count_d = count_m1;
        end else begin
          cur_d = step_rsp.nxt;
          wa_d  = cur_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ple_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    cur_q <= cur_d;
    wa_q  <= wa_d;
    lim_q <= lim_d;
    rd_q  <= rd_d;
    st_q  <= st_d;
  end

  assign done_o              = (state_q == ple_pkg::S_RESULT);
  assign result_o.read_value = rd_q;
  assign result_o.status     = st_q;
  assign result_o.length     = ple_pkg::LENW'(count_q);

  // An accepted command always leads to busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  // The result strobe is a single cycle and frees the command side.
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  // The store is only written while a command is in flight.
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> busy)
    else $error("store write while idle");

  // A full report comes only with a full store.
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status == ple_pkg::ST_FULL) |->
      (result_o.length == ple_pkg::LENW'(ple_pkg::DEPTH)))
    else $error("full status with room left");

  // Errors never return data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status != ple_pkg::ST_OK) |-> (result_o.read_value == '0))
    else $error("data returned on error");

  // Length never exceeds the capacity while a command is in flight.
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (count_q <= ple_pkg::CW'(ple_pkg::DEPTH)))
    else $error("length beyond capacity");

endmodule

`default_nettype wire
